### design/imu_pitch_roll_complementary_filter_assert.svh
// Assertion macros used by the filter's top-level RTL file.
`ifndef IMU_PITCH_ROLL_COMPLEMENTARY_FILTER_ASSERT_SVH
`define IMU_PITCH_ROLL_COMPLEMENTARY_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipr assertion failed");

`endif

### design/ipr_pkg.sv
// Shared constants, types and the table function of the pitch/roll filter.
`default_nettype none
package ipr_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int WEIGHT_W      = 16;
   localparam int PERIOD_W      = 24;
   localparam int ANGLE_W       = 24;
   localparam int CODE_W        = 15;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 24;

   localparam int ASIN_TABLE_DEPTH = 1024;
   localparam int ASIN_MAX_CODE    = 23041;

   localparam int ONE_G        = 8192;
   localparam int ONE_G_SHIFT  = 13;
   localparam int GYRO_SCALE   = 125;
   localparam int WEIGHT_ONE   = 65536;
   localparam int ACCEL_SHIFT  = 12;
   localparam int OUT_SHIFT    = 28;
   localparam int ROUND_HALF   = 1 << 27;
   localparam int ANGLE_MAX    = 8388607;
   localparam int ANGLE_MIN    = -8388608;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd62259;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_X_BIAS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_Y_BIAS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GYRO_X_BIAS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GYRO_Y_BIAS   = 3'd5;

   // Load strobes that the top level hands to each axis lane.
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s4_load;
      logic m_load;
      logic m_fire;
   } lane_ctrl_type;

   // Sine of a table code (1/256 degree at 57.3 degrees per radian) in Q30,
   // by a truncating Taylor series up to the 15th power. Elaboration only.
   function automatic longint sin_q30(input logic [CODE_W-1:0] a);
      longint unsigned r;
      longint unsigned r2;
      longint unsigned term;
      longint          acc;
      r    = (64'(a) * 64'd10 * (64'd1 << 30) + 64'd73344) / 64'd146688;
      r2   = (r * r) >> 30;
      term = r;
      acc  = longint'(r);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * r2) >> 30) / 64'(4 * k * k + 2 * k);
         if ((k % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

### design/ipr_asin_rom.sv
// Arcsine table with a registered read port, filled at elaboration.
`default_nettype none
module ipr_asin_rom #(
   parameter int ASIN_TABLE_DEPTH = ipr_pkg::ASIN_TABLE_DEPTH,
   localparam int IDX_W = $clog2(ASIN_TABLE_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [IDX_W-1:0]            rd_addr,
   output logic      [ipr_pkg::CODE_W-1:0]  rd_data_ff
);

   typedef logic [ipr_pkg::CODE_W-1:0] rom_type [0:ASIN_TABLE_DEPTH];

   // Entry i is the largest code whose sine stays at or below i / depth.
   function automatic rom_type build_rom();
      rom_type     t;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      longint      x;
      for (int i = 0; i <= ASIN_TABLE_DEPTH; i++) begin
         x  = longint'((64'(i) << 30) / 64'(ASIN_TABLE_DEPTH));
         lo = 0;
         hi = ipr_pkg::ASIN_MAX_CODE;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (ipr_pkg::sin_q30(ipr_pkg::CODE_W'(mid)) <= x) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         t[i] = ipr_pkg::CODE_W'(lo);
      end
      return t;
   endfunction

   localparam rom_type ROM_DATA = build_rom();

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ROM_DATA[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/ipr_lane.sv
// One axis of the filter: bias removal, arcsine lookup, products and state update.
`default_nettype none
module ipr_lane #(
   parameter int ASIN_TABLE_DEPTH = ipr_pkg::ASIN_TABLE_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ipr_pkg::lane_ctrl_type                ctrl,
   input  wire logic                                  accel_invert,
   input  wire logic signed [ipr_pkg::SAMPLE_W-1:0]   accel,
   input  wire logic signed [ipr_pkg::SAMPLE_W-1:0]   gyro,
   input  wire logic signed [ipr_pkg::SAMPLE_W-1:0]   accel_bias,
   input  wire logic signed [ipr_pkg::SAMPLE_W-1:0]   gyro_bias,
   input  wire logic        [ipr_pkg::WEIGHT_W-1:0]   weight,
   input  wire logic        [ipr_pkg::PERIOD_W-1:0]   period,
   output logic signed      [ipr_pkg::ANGLE_W-1:0]    angle_next,
   output logic signed      [ipr_pkg::ANGLE_W-1:0]    state_ff
);

   localparam int IDX_W  = $clog2(ASIN_TABLE_DEPTH + 1);
   localparam int PROD_W = ipr_pkg::ONE_G_SHIFT + 1 + IDX_W;
   localparam int DIFF_W = ipr_pkg::SAMPLE_W + 1;
   localparam int MAG_W  = ipr_pkg::ONE_G_SHIFT + 1;

   // Stage 1: bias removed, kept at 17 bits.
   logic signed [DIFF_W-1:0] ad_ff, ad_in;
   logic signed [DIFF_W-1:0] gd_ff, gd_in;

   assign ad_in = DIFF_W'(accel) - DIFF_W'(accel_bias);
   assign gd_in = DIFF_W'(gyro) - DIFF_W'(gyro_bias);

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         ad_ff <= ad_in;
         gd_ff <= gd_in;
      end
   end

   // Stage 2: clamp to one g, table index, gyro rate scaled by 125.
   logic [DIFF_W:0]          ad_ext;
   logic [DIFF_W:0]          mag;
   logic [MAG_W-1:0]         mag_clamp;
   logic [PROD_W-1:0]        idx_prod;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     neg2_ff, neg2_in;
   logic signed [23:0]       g125_ff, g125_in;

   assign ad_ext    = {ad_ff[DIFF_W-1], ad_ff};
   assign mag       = ad_ff[DIFF_W-1] ? (~ad_ext + 1'b1) : ad_ext;
   assign mag_clamp = (mag > (DIFF_W + 1)'(ipr_pkg::ONE_G)) ? MAG_W'(ipr_pkg::ONE_G)
                                                             : mag[MAG_W-1:0];
   assign idx_prod  = PROD_W'(mag_clamp) * PROD_W'(ASIN_TABLE_DEPTH)
                      + PROD_W'(ipr_pkg::ONE_G / 2);
   assign idx_in    = idx_prod[ipr_pkg::ONE_G_SHIFT +: IDX_W];
   assign neg2_in   = ad_ff[DIFF_W-1] ^ accel_invert;
   assign g125_in   = 24'(gd_ff) * 24'(ipr_pkg::GYRO_SCALE);

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         idx_ff  <= idx_in;
         neg2_ff <= neg2_in;
         g125_ff <= g125_in;
      end
   end

   // Stage 3: table read and gyro step product.
   logic [ipr_pkg::CODE_W-1:0] rom_q;
   logic                       neg3_ff;
   logic signed [48:0]         gp_ff, gp_in;

   ipr_asin_rom #(
      .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH)
   ) u_rom (
      .clock      (clock),
      .rd_en      (ctrl.s3_load),
      .rd_addr    (idx_ff),
      .rd_data_ff (rom_q)
   );

   assign gp_in = 49'(g125_ff) * $signed(49'({1'b0, period}));

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         neg3_ff <= neg2_ff;
         gp_ff   <= gp_in;
      end
   end

   // Stage 4: accelerometer term times (1 - w).
   logic signed [15:0]       a_signed;
   logic [16:0]              w_comp;
   logic signed [33:0]       ap_ff, ap_in;
   logic signed [48:0]       gp4_ff;

   assign a_signed = neg3_ff ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
   assign w_comp   = 17'(ipr_pkg::WEIGHT_ONE) - {1'b0, weight};
   assign ap_in    = 34'($signed({1'b0, w_comp})) * 34'(a_signed);

   always_ff @(posedge clock) begin
      if (ctrl.s4_load) begin
         ap_ff  <= ap_in;
         gp4_ff <= gp_ff;
      end
   end

   // State stage: w times state is taken only while no update is pending,
   // so the product always sees the state left by the previous word.
   logic signed [55:0]       other_ff, other_in;
   logic signed [40:0]       wst_ff, wst_in;
   logic signed [55:0]       sum;
   logic signed [27:0]       rounded;

   assign other_in = (56'(ap_ff) <<< ipr_pkg::ACCEL_SHIFT) + 56'(gp4_ff);
   assign wst_in   = 41'($signed({1'b0, weight})) * 41'(state_ff);

   always_ff @(posedge clock) begin
      if (ctrl.m_load) begin
         other_ff <= other_in;
         wst_ff   <= wst_in;
      end
   end

   assign sum     = (56'(wst_ff) <<< ipr_pkg::ACCEL_SHIFT) + other_ff
                    + 56'(ipr_pkg::ROUND_HALF);
   assign rounded = sum[55:ipr_pkg::OUT_SHIFT];

   always_comb begin
      if (rounded > 28'(ipr_pkg::ANGLE_MAX)) begin
         angle_next = ipr_pkg::ANGLE_W'(ipr_pkg::ANGLE_MAX);
      end else if (rounded < 28'(ipr_pkg::ANGLE_MIN)) begin
         angle_next = ipr_pkg::ANGLE_W'(ipr_pkg::ANGLE_MIN);
      end else begin
         angle_next = rounded[ipr_pkg::ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctrl.m_fire) begin
         state_ff <= angle_next;
      end
   end

endmodule
`default_nettype wire

### design/imu_pitch_roll_complementary_filter.sv
// Pitch/roll complementary filter top level: registers, lane control and output stage.
//
// Each accepted word carries one accelerometer x/y and gyro x/y sample set and
// produces one word with the updated pitch and roll in 1/256 degree. Two lanes,
// pitch and roll, run side by side through four feed stages (bias removal, clamp
// and table index, arcsine table read with the gyro step product, the (1 - w)
// product) and a state stage. A sample set enters the state stage only after
// the previous one has written its angle back, since the weight-times-state
// product is registered before the sum that writes the new angle back. Words
// are taken while a result still waits on the output. Both ready outputs are
// low while reset is held. Configuration writes take effect at once and are
// meant for times when no word is in flight.
`default_nettype none
`include "imu_pitch_roll_complementary_filter_assert.svh"
module imu_pitch_roll_complementary_filter #(
   parameter int ASIN_TABLE_DEPTH = ipr_pkg::ASIN_TABLE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: accel_x [15:0], accel_y [31:16], gyro_x [47:32], gyro_y [63:48]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [63:0]                         req_tdata,
   // rsp_tdata: pitch_angle [23:0], roll_angle [47:24]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [47:0]                              rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ipr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ipr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SW = ipr_pkg::SAMPLE_W;
   localparam int AW = ipr_pkg::ANGLE_W;

   // Configuration registers.
   logic [ipr_pkg::WEIGHT_W-1:0] weight_ff;
   logic [ipr_pkg::PERIOD_W-1:0] period_ff;
   logic signed [SW-1:0]         ax_bias_ff, ay_bias_ff, gx_bias_ff, gy_bias_ff;
   logic                         csr_write;

   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= ipr_pkg::WEIGHT_RESET;
         period_ff  <= ipr_pkg::PERIOD_RESET;
         ax_bias_ff <= '0;
         ay_bias_ff <= '0;
         gx_bias_ff <= '0;
         gy_bias_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ipr_pkg::REG_FILTER_WEIGHT: weight_ff  <= csr_data[ipr_pkg::WEIGHT_W-1:0];
            ipr_pkg::REG_SAMPLE_PERIOD: period_ff  <= csr_data[ipr_pkg::PERIOD_W-1:0];
            ipr_pkg::REG_ACCEL_X_BIAS:  ax_bias_ff <= csr_data[SW-1:0];
            ipr_pkg::REG_ACCEL_Y_BIAS:  ay_bias_ff <= csr_data[SW-1:0];
            ipr_pkg::REG_GYRO_X_BIAS:   gx_bias_ff <= csr_data[SW-1:0];
            ipr_pkg::REG_GYRO_Y_BIAS:   gy_bias_ff <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // Stage occupancy and load strobes.
   logic v1_ff, v2_ff, v3_ff, v4_ff, vm_ff, vout_ff;
   logic v1_in, v2_in, v3_in, v4_in, vm_in, vout_in;
   logic out_free;
   ipr_pkg::lane_ctrl_type ctrl;

   assign out_free     = !vout_ff || rsp_tready;
   assign ctrl.m_fire  = vm_ff && out_free;
   assign ctrl.m_load  = v4_ff && !vm_ff;
   assign ctrl.s4_load = v3_ff && (!v4_ff || ctrl.m_load);
   assign ctrl.s3_load = v2_ff && (!v3_ff || ctrl.s4_load);
   assign ctrl.s2_load = v1_ff && (!v2_ff || ctrl.s3_load);
   assign req_tready   = !reset && (!v1_ff || ctrl.s2_load);
   assign ctrl.s1_load = req_tvalid && req_tready;

   assign v1_in   = ctrl.s1_load || (v1_ff && !ctrl.s2_load);
   assign v2_in   = ctrl.s2_load || (v2_ff && !ctrl.s3_load);
   assign v3_in   = ctrl.s3_load || (v3_ff && !ctrl.s4_load);
   assign v4_in   = ctrl.s4_load || (v4_ff && !ctrl.m_load);
   assign vm_in   = ctrl.m_load  || (vm_ff && !ctrl.m_fire);
   assign vout_in = ctrl.m_fire  || (vout_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         vm_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         v4_ff   <= v4_in;
         vm_ff   <= vm_in;
         vout_ff <= vout_in;
      end
   end

   // Lanes: pitch uses accel x with inverted arcsine and gyro y; roll uses
   // accel y and gyro x.
   logic signed [AW-1:0] pitch_next, roll_next, pitch_state, roll_state;

   ipr_lane #(
      .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH)
   ) u_pitch (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .accel_invert (1'b1),
      .accel        (req_tdata[15:0]),
      .gyro         (req_tdata[63:48]),
      .accel_bias   (ax_bias_ff),
      .gyro_bias    (gy_bias_ff),
      .weight       (weight_ff),
      .period       (period_ff),
      .angle_next   (pitch_next),
      .state_ff     (pitch_state)
   );

   ipr_lane #(
      .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH)
   ) u_roll (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .accel_invert (1'b0),
      .accel        (req_tdata[31:16]),
      .gyro         (req_tdata[47:32]),
      .accel_bias   (ay_bias_ff),
      .gyro_bias    (gx_bias_ff),
      .weight       (weight_ff),
      .period       (period_ff),
      .angle_next   (roll_next),
      .state_ff     (roll_state)
   );

   // Merge both lanes into the output word.
   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.m_fire) begin
         rsp_data_ff <= {roll_next, pitch_next};
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A fired update shows up on the output together with the stored state.
   `IPR_ASSERT_NEXT(a_fire_to_output, clock, reset, ctrl.m_fire,
      rsp_tvalid && (rsp_tdata == {roll_state, pitch_state}))
   // The state loop admits no load right after a load.
   `IPR_ASSERT_NEXT(a_state_loop_spacing, clock, reset, ctrl.m_load,
      vm_ff && !ctrl.m_load)
   // A new word enters a full first stage only as that stage moves on.
   `IPR_ASSERT_SAME(a_stage1_no_overwrite, clock, reset, ctrl.s1_load && v1_ff,
      ctrl.s2_load)

endmodule
`default_nettype wire

### tb/imu_pitch_roll_complementary_filter_checker.sv
// Checker for the pitch/roll filter: watches all channels, predicts each angle word and compares.
`timescale 1ns / 100ps
module imu_pitch_roll_complementary_filter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [63:0]                       req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [47:0]                       rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [ipr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ipr_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                failures,
   output int                                pending_results,
   output int                                results_checked
);

   localparam int REPORT_LIMIT = 10;
   localparam int DEPTH        = ipr_pkg::ASIN_TABLE_DEPTH;

   // Arcsine codes in 1/256 degree, indexed by |acceleration| in steps of 1/DEPTH g.
   int unsigned arcsin_lut [0:DEPTH];

   logic        [ipr_pkg::WEIGHT_W-1:0]  gyro_weight;
   logic        [ipr_pkg::PERIOD_W-1:0]  step_period;
   logic signed [ipr_pkg::SAMPLE_W-1:0]  accel_x_offset;
   logic signed [ipr_pkg::SAMPLE_W-1:0]  accel_y_offset;
   logic signed [ipr_pkg::SAMPLE_W-1:0]  gyro_x_offset;
   logic signed [ipr_pkg::SAMPLE_W-1:0]  gyro_y_offset;
   logic signed [ipr_pkg::ANGLE_W-1:0]   pitch_now;
   logic signed [ipr_pkg::ANGLE_W-1:0]   roll_now;

   logic [47:0] expected_angles [$];
   int          fail_tally;
   int          compared;

   // Q30 sine of a code in 1/256 degree, truncating series up to the 15th power.
   function automatic longint sine_q30(input int unsigned code);
      longint unsigned rad;
      longint unsigned rad_sq;
      longint unsigned term;
      longint          total;
      rad   = (64'(code) * 64'd10 * (64'd1 << 30) + 64'd73344) / 64'd146688;
      rad_sq = (rad * rad) >> 30;
      term  = rad;
      total = longint'(rad);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            total = total - longint'(term);
         end else begin
            total = total + longint'(term);
         end
      end
      return total;
   endfunction

   // Largest code whose sine does not exceed the table point.
   function automatic int unsigned arcsin_entry(input int unsigned point);
      longint      target;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      target = longint'((64'(point) << 30) / 64'(DEPTH));
      lo = 0;
      hi = ipr_pkg::ASIN_MAX_CODE;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (sine_q30(mid) <= target) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   initial begin
      for (int i = 0; i <= DEPTH; i++) begin
         arcsin_lut[i] = arcsin_entry(i);
      end
   end

   // Tilt angle of one axis; the difference is clamped to +-1 g before lookup.
   function automatic int tilt_from_accel(input int diff);
      int mag;
      int point;
      int code;
      mag = (diff < 0) ? -diff : diff;
      if (mag > ipr_pkg::ONE_G) begin
         mag = ipr_pkg::ONE_G;
      end
      point = (mag * DEPTH + ipr_pkg::ONE_G / 2) / ipr_pkg::ONE_G;
      if (point > DEPTH) begin
         point = DEPTH;
      end
      code = int'(arcsin_lut[point]);
      return (diff < 0) ? -code : code;
   endfunction

   function automatic logic signed [ipr_pkg::ANGLE_W-1:0] blend_angle(
      input logic signed [ipr_pkg::ANGLE_W-1:0] angle,
      input int                                 tilt,
      input int                                 rate
   );
      longint acc;
      longint rounded;
      acc = (longint'(gyro_weight) * longint'(angle)
             + (longint'(ipr_pkg::WEIGHT_ONE) - longint'(gyro_weight)) * longint'(tilt))
            * (longint'(1) << ipr_pkg::ACCEL_SHIFT)
            + longint'(rate) * longint'(ipr_pkg::GYRO_SCALE) * longint'(step_period);
      rounded = (acc + (longint'(1) <<< 27)) >>> ipr_pkg::OUT_SHIFT;
      if (rounded > ipr_pkg::ANGLE_MAX) begin
         rounded = ipr_pkg::ANGLE_MAX;
      end else if (rounded < ipr_pkg::ANGLE_MIN) begin
         rounded = ipr_pkg::ANGLE_MIN;
      end
      return rounded[ipr_pkg::ANGLE_W-1:0];
   endfunction

   // Advances both angle states by one sample set and returns the packed result word.
   function automatic logic [47:0] predict_angles(input logic [63:0] word);
      int ax;
      int ay;
      int gx;
      int gy;
      ax = $signed(word[15:0]);
      ay = $signed(word[31:16]);
      gx = $signed(word[47:32]);
      gy = $signed(word[63:48]);
      ax = ax - accel_x_offset;
      ay = ay - accel_y_offset;
      gx = gx - gyro_x_offset;
      gy = gy - gyro_y_offset;
      pitch_now = blend_angle(pitch_now, -tilt_from_accel(ax), gy);
      roll_now  = blend_angle(roll_now, tilt_from_accel(ay), gx);
      return {roll_now, pitch_now};
   endfunction

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         gyro_weight    = ipr_pkg::WEIGHT_RESET;
         step_period    = ipr_pkg::PERIOD_RESET;
         accel_x_offset = '0;
         accel_y_offset = '0;
         gyro_x_offset  = '0;
         gyro_y_offset  = '0;
         pitch_now      = '0;
         roll_now       = '0;
         fail_tally     = 0;
         compared       = 0;
         expected_angles.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_angles.size() == 0) begin
               if (fail_tally < REPORT_LIMIT) begin
                  $display("%t: unexpected result word pitch %0d roll %0d", $realtime,
                           $signed(rsp_tdata[23:0]), $signed(rsp_tdata[47:24]));
               end
               fail_tally++;
            end else begin
               want = expected_angles.pop_front();
               compared++;
               if (rsp_tdata[23:0] !== want[23:0] || rsp_tdata[47:24] !== want[47:24]) begin
                  if (fail_tally < REPORT_LIMIT) begin
                     $display({"%t: angle mismatch: expected pitch %0d roll %0d,",
                               " got pitch %0d roll %0d"},
                              $realtime, $signed(want[23:0]), $signed(want[47:24]),
                              $signed(rsp_tdata[23:0]), $signed(rsp_tdata[47:24]));
                  end
                  fail_tally++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ipr_pkg::REG_FILTER_WEIGHT:
                  gyro_weight    = csr_data[ipr_pkg::WEIGHT_W-1:0];
               ipr_pkg::REG_SAMPLE_PERIOD:
                  step_period    = csr_data[ipr_pkg::PERIOD_W-1:0];
               ipr_pkg::REG_ACCEL_X_BIAS:
                  accel_x_offset = csr_data[ipr_pkg::SAMPLE_W-1:0];
               ipr_pkg::REG_ACCEL_Y_BIAS:
                  accel_y_offset = csr_data[ipr_pkg::SAMPLE_W-1:0];
               ipr_pkg::REG_GYRO_X_BIAS:
                  gyro_x_offset  = csr_data[ipr_pkg::SAMPLE_W-1:0];
               ipr_pkg::REG_GYRO_Y_BIAS:
                  gyro_y_offset  = csr_data[ipr_pkg::SAMPLE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_angles.push_back(predict_angles(req_tdata));
         end
      end
      pending_results <= expected_angles.size();
      failures        <= fail_tally;
      results_checked <= compared;
   end

endmodule

### tb/imu_pitch_roll_complementary_filter_tb.sv
// Top of the pitch/roll filter testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module imu_pitch_roll_complementary_filter_tb;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_WORDS     = 105;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam logic [ipr_pkg::CSR_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [ipr_pkg::CSR_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [63:0]                      req_tdata;   // accel_x, accel_y, gyro_x, gyro_y from bit 0 up
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [47:0]                      rsp_tdata;   // pitch_angle, roll_angle from bit 0 up
   logic                             csr_valid;
   logic                             csr_ready;
   logic [ipr_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [ipr_pkg::CSR_DATA_W-1:0]   csr_data;

   int failures;
   int pending_results;
   int results_checked;
   int cycle_count;
   int words_sent;
   int settings_used;
   bit gaps_on;
   bit hold_off_request;

   imu_pitch_roll_complementary_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   imu_pitch_roll_complementary_filter_checker u_angle_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("imu_pitch_roll_complementary_filter_tb: errors");
         $finish;
      end
   end

   // Result side: short random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic logic [15:0] accel_draw();
      if ($urandom_range(0, 7) == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(0, 18000) - 9000);
   endfunction

   function automatic logic [15:0] gyro_draw();
      case ($urandom_range(0, 7))
         6:       return 16'h7FFF;
         7:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] bias_draw();
      if ($urandom_range(0, 3) == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(0, 1000) - 500);
   endfunction

   // Leaves tvalid high after acceptance so back-to-back words need no re-raise.
   task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] gx, input logic [15:0] gy);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {gy, gx, ay, ax};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic write_register(input logic [ipr_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [ipr_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_until_drained();
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Upper bits of the 16-bit registers carry noise that the block must drop.
   task automatic apply_setting(input logic [15:0] weight, input logic [23:0] period,
                                input logic [15:0] axb, input logic [15:0] ayb,
                                input logic [15:0] gxb, input logic [15:0] gyb);
      write_register(ipr_pkg::REG_FILTER_WEIGHT, {8'($urandom), weight});
      write_register(ipr_pkg::REG_SAMPLE_PERIOD, period);
      write_register(ipr_pkg::REG_ACCEL_X_BIAS, {8'($urandom), axb});
      write_register(ipr_pkg::REG_ACCEL_Y_BIAS, {8'($urandom), ayb});
      write_register(ipr_pkg::REG_GYRO_X_BIAS, {8'($urandom), gxb});
      write_register(ipr_pkg::REG_GYRO_Y_BIAS, {8'($urandom), gyb});
      write_register($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 24'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [15:0] weight;
      logic [23:0] period;
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      gaps_on          = 1'b1;
      hold_off_request = 1'b0;
      words_sent       = 0;
      settings_used    = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: zero, full-scale, exactly one g and table rounding edges.
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_sample(16'd8192, -16'sd8192, 16'h0000, 16'h0000);
      send_sample(-16'sd8191, 16'd8191, 16'hFFFF, 16'h0001);
      send_sample(16'd4, -16'sd3, 16'h0000, 16'h0000);
      send_sample(-16'sd4, 16'd3, 16'h8000, 16'h7FFF);
      req_tvalid <= 1'b0;
      wait_until_drained();

      // Zero weight, largest step, biases that push the differences past 16 bits.
      apply_setting(16'd0, 24'hFFFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      req_tvalid <= 1'b0;
      wait_until_drained();

      // Full weight: both angles run into their limits and stay there.
      apply_setting(16'hFFFF, 24'hFFFFFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
      repeat (17) send_sample(accel_draw(), accel_draw(), 16'h8000, 16'h7FFF);
      req_tvalid <= 1'b0;
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               weight = 16'd0;
               period = 24'd0;
            end
            1: begin
               weight = 16'hFFFF;
               period = 24'hFFFFFF;
            end
            2: begin
               weight = ipr_pkg::WEIGHT_RESET;
               period = ipr_pkg::PERIOD_RESET;
            end
            default: begin
               weight = 16'($urandom);
               period = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
            end
         endcase
         apply_setting(weight, period, bias_draw(), bias_draw(), bias_draw(), bias_draw());
         gaps_on = (phase != RANDOM_PHASES - 1);
         if (phase == 2) begin
            hold_off_request = 1'b1;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase == 4 && n == 50) begin
               req_tvalid <= 1'b0;
               wait_until_drained();
            end
            send_sample(accel_draw(), accel_draw(), gyro_draw(), gyro_draw());
         end
         req_tvalid <= 1'b0;
         wait_until_drained();
      end

      repeat (10) @(posedge clock);
      $display("Sent %0d sample sets over %0d filter settings; %0d result words compared.",
               words_sent, settings_used, results_checked);
      $display("Covered clamped accelerations, saturated angles, zero and full weight, stalls.");
      if (failures == 0 && pending_results == 0) begin
         $display("imu_pitch_roll_complementary_filter_tb: clean");
      end else begin
         $display("imu_pitch_roll_complementary_filter_tb: errors");
      end
      $finish;
   end

endmodule
